// ===== sv/qrs_pkg.sv =====
// Package of the quadratic root solver: field widths, result kinds and the
// context and divider lane words that travel down the cell chains.
// No dependencies.
`default_nettype none
package qrs_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CW   = 32;        // coefficient width
  localparam int DW   = 66;        // discriminant magnitude width
  localparam int SQW  = 35;        // square root width, one bit per cell
  localparam int RADW = 2 * SQW;   // radicand width, two bits per cell
  localparam int SRW  = SQW + 2;   // square root remainder width
  localparam int NUMS = 37;        // signed numerator width
  localparam int NUMW = NUMS - 1;  // numerator magnitude width
  localparam int DENW = 34;        // signed denominator width
  localparam int DMW  = DENW - 1;  // denominator magnitude width
  localparam int QB   = 33;        // quotient bits, one per cell
  localparam int RW   = DMW + QB;  // divider remainder width

  localparam logic [CW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [QB-1:0] Q_POS_LIM = QB'(64'h7FFF_FFFF);
  localparam logic [QB-1:0] Q_NEG_LIM = QB'(64'h8000_0000);

  typedef enum logic [2:0] {
    KIND_TWO  = 3'd0,
    KIND_ONE  = 3'd1,
    KIND_CPLX = 3'd2,
    KIND_ZERO = 3'd3,
    KIND_NONE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic signed [CW-1:0]  a;
    logic signed [CW-1:0]  b;
    logic signed [CW-1:0]  c;
  } ctx_t;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [DMW-1:0] dm;
    logic [QB-1:0]  q;
    logic           neg;
    logic           big;
  } lane_t;

  function automatic logic [CW-1:0] abs32(input logic signed [CW-1:0] v);
    abs32 = v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // {overflow, value}
  function automatic logic [CW:0] sat_q(input logic [QB-1:0] q, input logic neg,
                                        input logic big);
    logic [CW:0] res;
    res = '0;
    if (big) begin
      res = {1'b1, neg ? Q_MIN : Q_MAX};
    end else if (neg) begin
      if (q > Q_NEG_LIM) res = {1'b1, Q_MIN};
      else res = {1'b0, (~q[CW-1:0]) + 32'd1};
    end else begin
      if (q > Q_POS_LIM) res = {1'b1, Q_MAX};
      else res = {1'b0, q[CW-1:0]};
    end
    sat_q = res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: products, discriminant, square
// root chain, divider chain and saturation. Depends on qrs_pkg and the cells.
//
// Takes a coefficient word every cycle (busy stays low) and gives one result
// word per input 72 cycles after the start edge, in input order, as a
// one-cycle out_valid strobe that the receiver must take. The latency is set
// by the 35 cells of the square root chain and the 33 cells of the divider
// chain, plus input, product, discriminant, divider setup and output stages.
`default_nettype none
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_coef_a,
  input  wire logic [31:0] in_coef_b,
  input  wire logic [31:0] in_coef_c,
  output logic             out_valid,
  output logic [2:0]       out_case_kind,
  output logic [31:0]      out_first_value,
  output logic [31:0]      out_second_value,
  output logic             out_overflow
);
  import qrs_pkg::*;

  localparam int NSW = NUMW + FRAC_BITS;

  // input stage
  logic s0_vld_r;
  ctx_t s0_ctx_r;

  // product stage
  logic        s1_vld_r;
  ctx_t        s1_ctx_r;
  logic [63:0] s1_b2_r, s1_p_r;
  logic        s1_acneg_r;

  // discriminant stage
  logic             s2_vld_r;
  ctx_t             s2_ctx_r, s2_ctx_nxt;
  logic [RADW-1:0]  s2_rad_r, s2_rad_nxt;
  logic [DW-1:0]    fl, b2x, dmag;
  logic             dneg;

  // square root chain
  logic            sq_vld  [SQW+1];
  ctx_t            sq_ctx  [SQW+1];
  logic [RADW-1:0] sq_rad  [SQW+1];
  logic [SQW-1:0]  sq_root [SQW+1];
  logic [SRW-1:0]  sq_rem  [SQW+1];

  // divider setup
  logic                   dp_vld_r;
  kind_t                  dp_kind_r;
  lane_t [1:0]            dp_lane_r, dp_lane_nxt;
  logic signed [NUMS-1:0] num [2];
  logic signed [DENW-1:0] den [2];
  logic signed [NUMS-1:0] sn, bn, cn;
  logic signed [DENW-1:0] a2, a2m;
  logic [NUMW-1:0]        nm [2];
  logic [NSW-1:0]         nsh [2];

  // divider chain
  logic        dv_vld  [QB+1];
  kind_t       dv_kind [QB+1];
  lane_t [1:0] dv_lane [QB+1];

  // output stage
  logic          o_vld_r;
  logic [2:0]    o_kind_r, o_kind_nxt;
  logic [CW-1:0] o_v1_r, o_v1_nxt, o_v2_r, o_v2_nxt;
  logic          o_ovf_r, o_ovf_nxt;
  logic [CW:0]   r1, r2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      dp_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      dp_vld_r <= sq_vld[SQW];
      o_vld_r  <= dv_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    s0_ctx_r <= '{kind: KIND_ZERO, a: in_coef_a, b: in_coef_b, c: in_coef_c};
    s1_ctx_r <= s0_ctx_r;
    s1_b2_r  <= 64'(abs32(s0_ctx_r.b)) * 64'(abs32(s0_ctx_r.b));
    s1_p_r   <= 64'(abs32(s0_ctx_r.a)) * 64'(abs32(s0_ctx_r.c));
    s1_acneg_r <= (s0_ctx_r.a[CW-1] != s0_ctx_r.c[CW-1]) && (s0_ctx_r.c != '0);
    s2_ctx_r <= s2_ctx_nxt;
    s2_rad_r <= s2_rad_nxt;
    dp_kind_r <= sq_ctx[SQW].kind;
    dp_lane_r <= dp_lane_nxt;
    o_kind_r <= o_kind_nxt;
    o_v1_r   <= o_v1_nxt;
    o_v2_r   <= o_v2_nxt;
    o_ovf_r  <= o_ovf_nxt;
  end

  // discriminant and classification
  always_comb begin
    fl   = {s1_p_r, 2'b00};
    b2x  = DW'(s1_b2_r);
    dneg = 1'b0;
    if (s1_acneg_r) begin
      dmag = b2x + fl;
    end else if (b2x >= fl) begin
      dmag = b2x - fl;
    end else begin
      dmag = fl - b2x;
      dneg = 1'b1;
    end
    s2_ctx_nxt = s1_ctx_r;
    if (s1_ctx_r.a == '0) begin
      if (s1_ctx_r.b == '0) s2_ctx_nxt.kind = (s1_ctx_r.c == '0) ? KIND_ZERO : KIND_NONE;
      else s2_ctx_nxt.kind = KIND_ONE;
    end else if (dneg) begin
      s2_ctx_nxt.kind = KIND_CPLX;
    end else if (dmag == '0) begin
      s2_ctx_nxt.kind = KIND_ONE;
    end else begin
      s2_ctx_nxt.kind = KIND_TWO;
    end
    s2_rad_nxt = RADW'(dmag);
  end

  assign sq_vld[0]  = s2_vld_r;
  assign sq_ctx[0]  = s2_ctx_r;
  assign sq_rad[0]  = s2_rad_r;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar g = 0; g < SQW; g++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[g]),
      .ctx_i  (sq_ctx[g]),
      .rad_i  (sq_rad[g]),
      .root_i (sq_root[g]),
      .rem_i  (sq_rem[g]),
      .vld_o  (sq_vld[g+1]),
      .ctx_o  (sq_ctx[g+1]),
      .rad_o  (sq_rad[g+1]),
      .root_o (sq_root[g+1]),
      .rem_o  (sq_rem[g+1])
    );
  end

  // numerators and denominators for each case
  always_comb begin
    sn  = NUMS'(signed'({1'b0, sq_root[SQW]}));
    bn  = NUMS'(sq_ctx[SQW].b);
    cn  = NUMS'(sq_ctx[SQW].c);
    a2  = DENW'(sq_ctx[SQW].a) <<< 1;
    a2m = a2[DENW-1] ? -a2 : a2;
    num[0] = -bn;
    den[0] = a2;
    num[1] = sn;
    den[1] = a2m;
    case (sq_ctx[SQW].kind)
      KIND_TWO: begin
        num[0] = -bn + sn;
        num[1] = -bn - sn;
        den[1] = a2;
      end
      KIND_ONE: begin
        if (sq_ctx[SQW].a == '0) begin
          num[0] = -cn;
          den[0] = DENW'(sq_ctx[SQW].b);
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 2; i++) begin
      nm[i]  = num[i][NUMS-1] ? NUMW'(-num[i]) : NUMW'(num[i]);
      nsh[i] = NSW'(nm[i]) << FRAC_BITS;
      dp_lane_nxt[i].dm  = den[i][DENW-1] ? DMW'(-den[i]) : DMW'(den[i]);
      dp_lane_nxt[i].neg = num[i][NUMS-1] != den[i][DENW-1];
      dp_lane_nxt[i].big = (nsh[i] >> QB) >= NSW'(dp_lane_nxt[i].dm);
      dp_lane_nxt[i].rem = RW'(nsh[i]);
      dp_lane_nxt[i].q   = '0;
    end
  end

  assign dv_vld[0]  = dp_vld_r;
  assign dv_kind[0] = dp_kind_r;
  assign dv_lane[0] = dp_lane_r;

  for (genvar g = 0; g < QB; g++) begin : g_div
    qrs_div_cell #(.SHIFT(QB - 1 - g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv_vld[g]),
      .kind_i (dv_kind[g]),
      .lane_i (dv_lane[g]),
      .vld_o  (dv_vld[g+1]),
      .kind_o (dv_kind[g+1]),
      .lane_o (dv_lane[g+1])
    );
  end

  // saturate, order and select
  always_comb begin
    r1 = sat_q(dv_lane[QB][0].q, dv_lane[QB][0].neg, dv_lane[QB][0].big);
    r2 = sat_q(dv_lane[QB][1].q, dv_lane[QB][1].neg, dv_lane[QB][1].big);
    o_kind_nxt = dv_kind[QB];
    o_v1_nxt   = '0;
    o_v2_nxt   = '0;
    o_ovf_nxt  = 1'b0;
    case (dv_kind[QB])
      KIND_TWO: begin
        o_ovf_nxt = r1[CW] | r2[CW];
        if ($signed(r1[CW-1:0]) < $signed(r2[CW-1:0])) begin
          o_v1_nxt = r2[CW-1:0];
          o_v2_nxt = r1[CW-1:0];
        end else begin
          o_v1_nxt = r1[CW-1:0];
          o_v2_nxt = r2[CW-1:0];
        end
      end
      KIND_ONE: begin
        o_ovf_nxt = r1[CW];
        o_v1_nxt  = r1[CW-1:0];
      end
      KIND_CPLX: begin
        o_ovf_nxt = r1[CW] | r2[CW];
        o_v1_nxt  = r1[CW-1:0];
        o_v2_nxt  = r2[CW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = o_vld_r;
  assign out_case_kind    = o_kind_r;
  assign out_first_value  = o_v1_r;
  assign out_second_value = o_v2_r;
  assign out_overflow     = o_ovf_r;

endmodule
`default_nettype wire

// ===== sv/qrs_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per word.
// Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   vld_i,
  input  wire qrs_pkg::ctx_t          ctx_i,
  input  wire logic [qrs_pkg::RADW-1:0] rad_i,
  input  wire logic [qrs_pkg::SQW-1:0]  root_i,
  input  wire logic [qrs_pkg::SRW-1:0]  rem_i,
  output logic                        vld_o,
  output qrs_pkg::ctx_t               ctx_o,
  output logic [qrs_pkg::RADW-1:0]    rad_o,
  output logic [qrs_pkg::SQW-1:0]     root_o,
  output logic [qrs_pkg::SRW-1:0]     rem_o
);
  import qrs_pkg::*;

  logic            vld_r;
  ctx_t            ctx_r;
  logic [RADW-1:0] rad_r, rad_nxt;
  logic [SQW-1:0]  root_r, root_nxt;
  logic [SRW-1:0]  rem_r, rem_nxt;
  logic [SRW+1:0]  rem_sh, trial;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_i, rad_i[RADW-1 -: 2]};
    trial    = (SRW+2)'({root_i, 2'b01});
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? SRW'(rem_sh - trial) : SRW'(rem_sh);
    root_nxt = {root_i[SQW-2:0], ge};
    rad_nxt  = rad_i << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    ctx_r  <= ctx_i;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign vld_o  = vld_r;
  assign ctx_o  = ctx_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule
`default_nettype wire

// ===== sv/qrs_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit in each of two lanes.
// Depends on qrs_pkg.
`default_nettype none
module qrs_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                vld_i,
  input  wire qrs_pkg::kind_t      kind_i,
  input  wire qrs_pkg::lane_t [1:0] lane_i,
  output logic                     vld_o,
  output qrs_pkg::kind_t           kind_o,
  output qrs_pkg::lane_t [1:0]     lane_o
);
  import qrs_pkg::*;

  logic          vld_r;
  kind_t         kind_r;
  lane_t [1:0]   lane_r, lane_nxt;
  logic [RW-1:0] dsh [2];
  logic          ge [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lane_nxt[i] = lane_i[i];
      dsh[i] = RW'(lane_i[i].dm) << SHIFT;
      ge[i]  = lane_i[i].rem >= dsh[i];
      if (ge[i]) lane_nxt[i].rem = lane_i[i].rem - dsh[i];
      lane_nxt[i].q = {lane_i[i].q[QB-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_i;
    lane_r <= lane_nxt;
  end

  assign vld_o  = vld_r;
  assign kind_o = kind_r;
  assign lane_o = lane_r;

endmodule
`default_nettype wire

// ===== sv/qrs_checker.sv =====
// Port-level checks for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg.
`default_nettype none
module qrs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic [2:0]  out_case_kind,
  input wire logic [31:0] out_first_value,
  input wire logic [31:0] out_second_value,
  input wire logic        out_overflow
);
  import qrs_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word after reset");

  a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_case_kind == 3'(KIND_ZERO) || out_case_kind == 3'(KIND_NONE))
      |-> out_first_value == '0 && out_second_value == '0 && !out_overflow)
    else $error("nonzero value for degenerate equation");

  a_two_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_kind == 3'(KIND_TWO)
      |-> $signed(out_first_value) >= $signed(out_second_value))
    else $error("real roots out of order");

  a_one_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_kind == 3'(KIND_ONE) |-> out_second_value == '0)
    else $error("single root with nonzero second value");

  a_imag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_kind == 3'(KIND_CPLX) |-> !out_second_value[31])
    else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_case_kind    (out_case_kind),
  .out_first_value  (out_first_value),
  .out_second_value (out_second_value),
  .out_overflow     (out_overflow)
);
`default_nettype wire
